// File: src/mom_pkg.sv
// Mirrored offset mapper package: field widths, status codes, register
// indexes and the sequencer state type. No dependencies.
package mom_pkg;

  localparam int unsigned MaxNodesDefault = 16;
  localparam int unsigned MaxResults      = 16;

  localparam int unsigned OffsetW    = 40;
  localparam int unsigned LengthW    = 32;
  localparam int unsigned RegionW    = 32;
  localparam int unsigned CfgNodeW   = 5;
  localparam int unsigned CfgCopyW   = 5;
  localparam int unsigned NodeIndexW = 4;
  localparam int unsigned NodeOffW   = 33;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned ResCntW    = $clog2(MaxResults);
  localparam int unsigned DivCntW    = $clog2(OffsetW);

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StRange  = 2'd1;
  localparam logic [StatusW-1:0] StCopies = 2'd2;

  localparam logic [CfgIndexW-1:0] RegNodeCount  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegRegionSize = 2'd1;
  localparam logic [CfgIndexW-1:0] RegCopyCount  = 2'd2;

  typedef enum logic [1:0] {
    StateIdle,
    StateDiv,
    StateEmit
  } state_e;

endpackage

// File: src/mirrored_offset_mapper_unit.sv
// Mirrored offset mapper top level: bit-serial offset divider and target
// sequencer with a registered result word. Depends on mom_pkg.
//
// Usage:
//   Request words enter on in_valid_i / in_stall_o (mode, offset, length).
//   Target words leave on out_valid_o / out_stall_i, one per copy, with
//   out_last_o marking the final word of a request. Reads, errors and
//   writes with copy_count <= 1 give one word; other writes give copy_count
//   words (primary, then backups on next nodes at local offset + region size).
//   Registers are written on cfg_valid_i / cfg_ready_o (always ready);
//   write them only while no request is in flight.
// Timing:
//   The offset is divided by region_size one quotient bit per cycle by a
//   restoring divider. Targets then load the output register at one per
//   cycle while the receiver takes them. A new request is taken as soon as
//   the last word sits in the output register.
// Reset:
//   Clears the sequencer and output valid; node_count 1, region_size 1,
//   copy_count 0. A stalled receiver holds the output word and the
//   sequencer waits; no word is dropped.
module mirrored_offset_mapper_unit #(
  parameter int unsigned MAX_NODES = mom_pkg::MaxNodesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mom_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [mom_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_mode_i,
  input  logic [mom_pkg::OffsetW-1:0]     in_offset_i,
  input  logic [mom_pkg::LengthW-1:0]     in_length_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mom_pkg::NodeIndexW-1:0]  out_node_index_o,
  output logic [mom_pkg::NodeOffW-1:0]    out_node_offset_o,
  output logic [mom_pkg::LengthW-1:0]     out_req_length_o,
  output logic                            out_is_backup_o,
  output logic [mom_pkg::StatusW-1:0]     out_status_o,
  output logic                            out_last_o
);

  localparam int unsigned NodeW = $clog2(MAX_NODES + 1);
  localparam int unsigned CmpW  = (NodeW > mom_pkg::CfgNodeW) ? NodeW : mom_pkg::CfgNodeW;
  localparam int unsigned IdxW  = $clog2(MAX_NODES);
  localparam logic [CmpW-1:0] MaxNodesC = CmpW'(MAX_NODES);
  localparam logic [CmpW-1:0] MaxResC   = CmpW'(mom_pkg::MaxResults);
  localparam logic [mom_pkg::DivCntW-1:0] DivLast = mom_pkg::DivCntW'(mom_pkg::OffsetW - 1);

  // configuration registers
  logic [mom_pkg::CfgNodeW-1:0] node_count_q;
  logic [mom_pkg::RegionW-1:0]  region_size_q;
  logic [mom_pkg::CfgCopyW-1:0] copy_count_q;

  // sequencer and divider
  mom_pkg::state_e               state_q, state_d;
  logic [mom_pkg::OffsetW-1:0]   work_q;
  logic [mom_pkg::RegionW-1:0]   rem_q, rem_d;
  logic [mom_pkg::DivCntW-1:0]   bit_cnt_q;
  logic                          mode_q;
  logic [mom_pkg::LengthW-1:0]   length_q;
  logic [mom_pkg::ResCntW-1:0]   res_cnt_q;
  logic [IdxW-1:0]               idx_q;

  // output register
  logic                            out_valid_q;
  logic [mom_pkg::NodeIndexW-1:0]  node_index_q;
  logic [mom_pkg::NodeOffW-1:0]    node_offset_q;
  logic [mom_pkg::LengthW-1:0]     req_length_q;
  logic                            is_backup_q;
  logic [mom_pkg::StatusW-1:0]     status_q;
  logic                            last_q;

  logic                          in_accept;
  logic                          load_out;
  logic [mom_pkg::RegionW:0]     shifted;
  logic [mom_pkg::RegionW+1:0]   trial;
  logic                          q_bit;
  logic [CmpW-1:0]               nodes;
  logic                          range_err;
  logic                          copy_err;
  logic                          any_err;
  logic                          single;
  logic                          first;
  logic [CmpW-1:0]               idx_inc;
  logic [CmpW-1:0]               node_sel;
  logic                          emit_last;
  logic [mom_pkg::NodeOffW-1:0]  backup_off;
  logic [mom_pkg::StatusW-1:0]   status_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= mom_pkg::CfgNodeW'(1);
      region_size_q <= mom_pkg::RegionW'(1);
      copy_count_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mom_pkg::RegNodeCount:  node_count_q  <= cfg_data_i[mom_pkg::CfgNodeW-1:0];
        mom_pkg::RegRegionSize: region_size_q <= cfg_data_i[mom_pkg::RegionW-1:0];
        mom_pkg::RegCopyCount:  copy_count_q  <= cfg_data_i[mom_pkg::CfgCopyW-1:0];
        default: ;
      endcase
    end
  end

  // restoring divider step
  always_comb begin
    shifted = {rem_q, work_q[mom_pkg::OffsetW-1]};
    trial   = {1'b0, shifted} - {2'b00, region_size_q};
    q_bit   = !trial[mom_pkg::RegionW+1];
    rem_d   = q_bit ? trial[mom_pkg::RegionW-1:0] : shifted[mom_pkg::RegionW-1:0];
  end

  // target selection
  always_comb begin
    nodes = (CmpW'(node_count_q) > MaxNodesC) ? MaxNodesC : CmpW'(node_count_q);
    range_err = (region_size_q == '0) || (nodes == '0)
             || (work_q >= {{(mom_pkg::OffsetW - CmpW){1'b0}}, nodes});
    copy_err  = (CmpW'(copy_count_q) > nodes) || (CmpW'(copy_count_q) > MaxResC);
    any_err   = range_err || copy_err;
    single    = any_err || !mode_q || (copy_count_q <= mom_pkg::CfgCopyW'(1));
    first     = (res_cnt_q == '0);
    idx_inc   = {{(CmpW - IdxW){1'b0}}, idx_q} + CmpW'(1);
    if (first) begin
      node_sel = {{(CmpW - IdxW){1'b0}}, work_q[IdxW-1:0]};
    end else if (idx_inc == nodes) begin
      node_sel = '0;
    end else begin
      node_sel = idx_inc;
    end
    emit_last  = single
              || ({1'b0, res_cnt_q} + mom_pkg::CfgCopyW'(1) == copy_count_q);
    backup_off = {1'b0, rem_q} + {1'b0, region_size_q};
    if (range_err) begin
      status_d = mom_pkg::StRange;
    end else if (copy_err) begin
      status_d = mom_pkg::StCopies;
    end else begin
      status_d = mom_pkg::StOk;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mom_pkg::StateIdle: if (in_valid_i) state_d = mom_pkg::StateDiv;
      mom_pkg::StateDiv:  if (bit_cnt_q == DivLast) state_d = mom_pkg::StateEmit;
      mom_pkg::StateEmit: if (load_out && emit_last) state_d = mom_pkg::StateIdle;
      default:            state_d = mom_pkg::StateIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != mom_pkg::StateIdle);
    in_accept  = in_valid_i && !in_stall_o;
    load_out   = (state_q == mom_pkg::StateEmit) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mom_pkg::StateIdle;
      bit_cnt_q <= '0;
      res_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        bit_cnt_q <= '0;
        res_cnt_q <= '0;
      end else if (state_q == mom_pkg::StateDiv) begin
        bit_cnt_q <= bit_cnt_q + mom_pkg::DivCntW'(1);
      end else if (load_out) begin
        res_cnt_q <= emit_last ? '0 : res_cnt_q + mom_pkg::ResCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      work_q   <= in_offset_i;
      rem_q    <= '0;
      mode_q   <= in_mode_i;
      length_q <= in_length_i;
    end else if (state_q == mom_pkg::StateDiv) begin
      work_q <= {work_q[mom_pkg::OffsetW-2:0], q_bit};
      rem_q  <= rem_d;
    end
    if (load_out) begin
      idx_q <= node_sel[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      node_index_q  <= any_err ? '0 : node_sel[mom_pkg::NodeIndexW-1:0];
      node_offset_q <= any_err ? '0 : (first ? {1'b0, rem_q} : backup_off);
      req_length_q  <= length_q;
      is_backup_q   <= !any_err && !first;
      status_q      <= status_d;
      last_q        <= emit_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_node_index_o  = node_index_q;
  assign out_node_offset_o = node_offset_q;
  assign out_req_length_o  = req_length_q;
  assign out_is_backup_o   = is_backup_q;
  assign out_status_o      = status_q;
  assign out_last_o        = last_q;

  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != mom_pkg::StOk) |-> out_last_o && !out_is_backup_o)
    else $error("error word is not a single primary word");

  a_backup_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_is_backup_o |-> (out_status_o == mom_pkg::StOk))
    else $error("backup word carries an error status");

  a_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mom_pkg::StateDiv) && (bit_cnt_q == DivLast)
      |=> (state_q == mom_pkg::StateEmit) && (res_cnt_q == '0))
    else $error("divider did not hand over to the target sequencer");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mom_pkg::StateEmit) && !(load_out && emit_last) |=> in_stall_o)
    else $error("request taken while targets remain");

endmodule

// File: dv/tb_mirrored_offset_mapper_unit.sv
// Testbench for mirrored_offset_mapper_unit: drives request words, predicts the target
// words of each request and checks every word leaving the block, field by field.
// Depends on mom_pkg and the block's RTL; needs nothing else.
`timescale 1ns / 100ps

module tb_mirrored_offset_mapper_unit;

  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned IdleGap    = 8;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseItems = 24;

  typedef struct packed {
    logic [mom_pkg::NodeIndexW-1:0] node;
    logic [mom_pkg::NodeOffW-1:0]   noff;
    logic [mom_pkg::LengthW-1:0]    len;
    logic                           backup;
    logic [mom_pkg::StatusW-1:0]    status;
    logic                           last;
  } target_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [mom_pkg::CfgIndexW-1:0]   cfg_index_i;
  logic [mom_pkg::CfgDataW-1:0]    cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic                            in_mode_i;
  logic [mom_pkg::OffsetW-1:0]     in_offset_i;
  logic [mom_pkg::LengthW-1:0]     in_length_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [mom_pkg::NodeIndexW-1:0]  out_node_index_o;
  logic [mom_pkg::NodeOffW-1:0]    out_node_offset_o;
  logic [mom_pkg::LengthW-1:0]     out_req_length_o;
  logic                            out_is_backup_o;
  logic [mom_pkg::StatusW-1:0]     out_status_o;
  logic                            out_last_o;

  logic [mom_pkg::CfgNodeW-1:0] node_count_q;
  logic [mom_pkg::RegionW-1:0]  region_size_q;
  logic [mom_pkg::CfgCopyW-1:0] copy_count_q;

  target_t pending_targets[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_tick;
  logic [31:0] stall_pat;

  mirrored_offset_mapper_unit #(
    .MAX_NODES(mom_pkg::MaxNodesDefault)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_mode_i        (in_mode_i),
    .in_offset_i      (in_offset_i),
    .in_length_i      (in_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_node_index_o (out_node_index_o),
    .out_node_offset_o(out_node_offset_o),
    .out_req_length_o (out_req_length_o),
    .out_is_backup_o  (out_is_backup_o),
    .out_status_o     (out_status_o),
    .out_last_o       (out_last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stall pattern, reloaded whenever stall_tick wraps to zero.
  always @(negedge clk_i) begin
    if (stall_tick == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = '0;
        1: stall_pat = $urandom & $urandom;
        2: stall_pat = $urandom;
        default: stall_pat = 32'h4924_9249;
      endcase
    end
    stall_tick = (stall_tick + 1) % 48;
    out_stall_i = stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[31:1]};
  end

  always @(posedge clk_i) begin
    target_t got;
    target_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_node_index_o, out_node_offset_o, out_req_length_o, out_is_backup_o,
              out_status_o, out_last_o};
      if (pending_targets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word node %0d off %h len %h bk %b st %0d last %b",
                   $realtime, got.node, got.noff, got.len, got.backup, got.status, got.last);
      end else begin
        want = pending_targets.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: word mismatch exp node %0d off %h len %h bk %b st %0d last %b,",
                      " got node %0d off %h len %h bk %b st %0d last %b"},
                     $realtime, want.node, want.noff, want.len, want.backup, want.status,
                     want.last, got.node, got.noff, got.len, got.backup, got.status,
                     got.last);
        end
      end
    end
  end

  function automatic logic [63:0] active_nodes();
    return (node_count_q > mom_pkg::MaxNodesDefault) ? 64'(mom_pkg::MaxNodesDefault)
                                                     : 64'(node_count_q);
  endfunction

  function automatic void map_request(input logic mode,
                                      input logic [mom_pkg::OffsetW-1:0] off,
                                      input logic [mom_pkg::LengthW-1:0] len);
    logic [63:0] nodes;
    logic [63:0] span;
    logic [63:0] region;
    logic [63:0] pidx;
    logic [63:0] poff;
    logic [63:0] idx;
    target_t t;
    int unsigned i;
    nodes  = active_nodes();
    region = 64'(region_size_q);
    span   = nodes * region;
    t      = '0;
    t.len  = len;
    t.last = 1'b1;
    if (region == 0 || nodes == 0 || 64'(off) >= span) begin
      t.status = mom_pkg::StRange;
      pending_targets.push_back(t);
      return;
    end
    if (64'(copy_count_q) > nodes || copy_count_q > mom_pkg::MaxResults) begin
      t.status = mom_pkg::StCopies;
      pending_targets.push_back(t);
      return;
    end
    pidx     = 64'(off) / region;
    poff     = 64'(off) % region;
    t.status = mom_pkg::StOk;
    t.node   = pidx[mom_pkg::NodeIndexW-1:0];
    t.noff   = poff[mom_pkg::NodeOffW-1:0];
    if (mode == ModeRead || copy_count_q <= 1) begin
      pending_targets.push_back(t);
      return;
    end
    t.last = 1'b0;
    pending_targets.push_back(t);
    idx = pidx;
    for (i = 1; i < copy_count_q; i++) begin
      idx      = (idx + 1) % nodes;
      t.node   = idx[mom_pkg::NodeIndexW-1:0];
      t.noff   = mom_pkg::NodeOffW'(poff + region);
      t.backup = 1'b1;
      t.last   = (i + 1 == copy_count_q);
      pending_targets.push_back(t);
    end
  endfunction

  task automatic write_reg(input logic [mom_pkg::CfgIndexW-1:0] index,
                           input logic [mom_pkg::CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      mom_pkg::RegNodeCount:  node_count_q  = data[mom_pkg::CfgNodeW-1:0];
      mom_pkg::RegRegionSize: region_size_q = data[mom_pkg::RegionW-1:0];
      mom_pkg::RegCopyCount:  copy_count_q  = data[mom_pkg::CfgCopyW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_layout(input logic [mom_pkg::CfgDataW-1:0] nodes,
                            input logic [mom_pkg::CfgDataW-1:0] region,
                            input logic [mom_pkg::CfgDataW-1:0] copies);
    write_reg(mom_pkg::RegNodeCount, nodes);
    write_reg(mom_pkg::RegRegionSize, region);
    write_reg(mom_pkg::RegCopyCount, copies);
  endtask

  task automatic send_request(input logic mode, input logic [mom_pkg::OffsetW-1:0] off,
                              input logic [mom_pkg::LengthW-1:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_valid_i  = 1'b1;
    in_mode_i   = mode;
    in_offset_i = off;
    in_length_i = len;
    do @(posedge clk_i); while (in_stall_o);
    map_request(mode, off, len);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every target word has been seen.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_targets.size() != 0) @(negedge clk_i);
    repeat (IdleGap) @(negedge clk_i);
  endtask

  task automatic test_reset_layout();
    send_request(ModeRead, '0, '0);
    send_request(ModeWrite, '0, 32'hFFFF_FFFF);
    send_request(ModeRead, 40'd1, 32'h1234_5678);
    send_request(ModeWrite, 40'hFF_FFFF_FFFF, '0);
    wait_idle();
  endtask

  task automatic test_wrap_mapping();
    set_layout(32'd4, 32'h100, 32'd3);
    send_request(ModeWrite, 40'h3FF, 32'hA5A5_0001);
    send_request(ModeWrite, 40'h000, 32'h0000_0002);
    send_request(ModeRead, 40'h2FF, 32'h0000_0003);
    send_request(ModeWrite, 40'h400, 32'h0000_0004);
    wait_idle();
    write_reg(mom_pkg::RegCopyCount, 32'd4);
    send_request(ModeWrite, 40'h150, 32'h5A5A_0005);
    wait_idle();
    write_reg(mom_pkg::RegCopyCount, 32'd5);
    send_request(ModeWrite, 40'h0, 32'h0000_0006);
    send_request(ModeRead, 40'h0, 32'h0000_0007);
    send_request(ModeWrite, 40'h400, 32'h0000_0008);
    wait_idle();
    write_reg(mom_pkg::RegCopyCount, 32'd0);
    send_request(ModeWrite, 40'h10, 32'h0000_0009);
    wait_idle();
    write_reg(mom_pkg::RegCopyCount, 32'd1);
    send_request(ModeWrite, 40'h210, 32'h0000_000A);
    wait_idle();
  endtask

  task automatic test_layout_extremes();
    set_layout(32'd0, 32'h100, 32'd0);
    send_request(ModeRead, 40'h0, 32'hFFFF_FFFF);
    wait_idle();
    set_layout(32'd31, 32'hFFFF_FFFF, 32'd16);
    send_request(ModeWrite, 40'hF_FFFF_FFEF, 32'h8000_0000);
    send_request(ModeWrite, 40'h0, 32'h7FFF_FFFF);
    send_request(ModeRead, 40'hF_FFFF_FFF0, 32'h0000_0001);
    wait_idle();
    write_reg(mom_pkg::RegCopyCount, 32'd17);
    send_request(ModeWrite, 40'h1234, 32'h0000_0002);
    wait_idle();
    write_reg(mom_pkg::RegCopyCount, 32'd31);
    send_request(ModeRead, 40'h5678, 32'h0000_0003);
    wait_idle();
    write_reg(mom_pkg::RegRegionSize, 32'd0);
    send_request(ModeWrite, 40'h0, 32'h0000_0004);
    wait_idle();
  endtask

  task automatic test_random_requests();
    logic [63:0] nodes;
    logic [63:0] span;
    logic [63:0] pick;
    logic [31:0] nval;
    logic [31:0] rval;
    logic [31:0] cval;
    logic [mom_pkg::OffsetW-1:0] off;
    int unsigned p;
    int unsigned n;
    for (p = 0; p < RandPhases; p++) begin
      case ($urandom_range(0, 7))
        0: nval = 32'd0;
        1: nval = $urandom_range(17, 31);
        default: nval = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 11))
        0: rval = 32'd0;
        1: rval = 32'hFFFF_FFFF;
        2, 3: rval = $urandom;
        4, 5: rval = $urandom_range(1, 65535);
        default: rval = $urandom_range(1, 64);
      endcase
      if (p == 0) begin
        nval = 32'd16;
        rval = 32'hFFFF_FFFF;
      end else if (p == 1) begin
        nval = 32'd1;
        rval = 32'd1;
      end
      nodes = (nval[mom_pkg::CfgNodeW-1:0] > mom_pkg::MaxNodesDefault)
              ? 64'(mom_pkg::MaxNodesDefault) : 64'(nval[mom_pkg::CfgNodeW-1:0]);
      case ($urandom_range(0, 7))
        0: cval = $urandom_range(17, 31);
        1: cval = 32'(nodes + 1);
        default: cval = $urandom_range(0, 32'(nodes));
      endcase
      if (p == 0) cval = 32'd16;
      if ($urandom_range(0, 1) == 1) begin
        nval = nval | ($urandom & 32'hFFFF_FFE0);
        cval = cval | ($urandom & 32'hFFFF_FFE0);
      end
      set_layout(nval, rval, cval);
      span = nodes * 64'(rval);
      for (n = 0; n < PhaseItems; n++) begin
        pick = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          6: off = (span == 0) ? pick[mom_pkg::OffsetW-1:0] :
                   mom_pkg::OffsetW'(64'($urandom_range(0, 32'(nodes) - 1)) * 64'(rval) +
                                     (pick[63] ? 64'(rval) - 1 : 64'd0));
          7: off = (span == 0) ? '0 : mom_pkg::OffsetW'(span - 1);
          8: off = mom_pkg::OffsetW'(span);
          9: off = pick[mom_pkg::OffsetW-1:0];
          default: off = (span == 0) ? pick[mom_pkg::OffsetW-1:0]
                                     : mom_pkg::OffsetW'(pick % span);
        endcase
        send_request(($urandom_range(0, 3) != 0) ? ModeWrite : ModeRead, off, $urandom);
      end
      wait_idle();
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_mode_i     = ModeRead;
    in_offset_i   = '0;
    in_length_i   = '0;
    out_stall_i   = 1'b0;
    stall_pat     = '0;
    stall_tick    = 0;
    burst_left    = 0;
    mismatches    = 0;
    cycle_count   = 0;
    node_count_q  = mom_pkg::CfgNodeW'(1);
    region_size_q = mom_pkg::RegionW'(1);
    copy_count_q  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_layout();
    test_wrap_mapping();
    test_layout_extremes();
    test_random_requests();

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (pending_targets.size() != 0) begin
      mismatches += pending_targets.size();
      $display("%0d target words never arrived", pending_targets.size());
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
